[rtl/tcw_pkg.sv]
// Shared types and constants of the text console character writer.
package tcw_pkg;

  localparam int unsigned ColW  = 7;
  localparam int unsigned RowW  = 8;
  localparam int unsigned AddrW = 15;
  localparam int unsigned CharW = 8;
  localparam int unsigned AttrW = 8;
  localparam int unsigned CellW = 16;

  localparam logic [AttrW-1:0] AttrReset = 8'h34;

  localparam logic [CharW-1:0] CharBackspace = 8'h08;
  localparam logic [CharW-1:0] CharTab       = 8'h09;
  localparam logic [CharW-1:0] CharNewline   = 8'h0A;
  localparam logic [CharW-1:0] CharReturn    = 8'h0D;

  localparam int unsigned TabStop = 8;

  typedef struct packed {
    logic             cell_write;
    logic [AddrW-1:0] cell_address;
    logic [CellW-1:0] cell_value;
    logic [AddrW-1:0] cursor_position;
  } tcw_result_t;

endpackage

[rtl/tcw_if.sv]
// Valid/ready channel interfaces for characters in and cell results out.
interface tcw_char_if import tcw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface tcw_cell_if import tcw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cell_write;
  logic [AddrW-1:0] cell_address;
  logic [CellW-1:0] cell_value;
  logic [AddrW-1:0] cursor_position;

  modport source (output valid, output cell_write, output cell_address, output cell_value,
                  output cursor_position, input ready);
  modport sink (input valid, input cell_write, input cell_address, input cell_value,
                input cursor_position, output ready);
endinterface

[rtl/tcw_cursor.sv]
// Cursor state and the per-character cell write and position computation.
module tcw_cursor import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = 80
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [CharW-1:0] char_code_i,
  input  logic [AttrW-1:0] attribute_i,
  output tcw_result_t      result_o
);

  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  // Row start address, row * COLUMNS, kept alongside the row to avoid a multiplier.
  logic [AddrW-1:0] base_q, base_d;

  logic [ColW:0]    col_ext;
  logic [ColW:0]    col_next;
  logic             newline;
  logic             row_inc;
  logic             printable;

  assign col_ext   = {1'b0, col_q};
  assign printable = (char_code_i[7] == 1'b0) && (char_code_i[6:5] != 2'b00);

  always_comb begin
    col_next = col_ext;
    newline  = 1'b0;
    unique case (char_code_i)
      CharNewline: begin
        col_next = '0;
        newline  = 1'b1;
      end
      CharReturn: begin
        col_next = '0;
      end
      CharTab: begin
        col_next = (col_ext + (ColW+1)'(TabStop)) & ~(ColW+1)'(TabStop - 1);
      end
      CharBackspace: begin
        if (col_q != '0) begin
          col_next = col_ext - (ColW+1)'(1);
        end
      end
      default: begin
        if (printable) begin
          col_next = col_ext + (ColW+1)'(1);
        end
      end
    endcase
  end

  // Reaching the column limit wraps to the start of the next row.
  always_comb begin
    col_d   = col_next[ColW-1:0];
    row_inc = newline;
    if (col_next >= (ColW+1)'(COLUMNS)) begin
      col_d   = '0;
      row_inc = 1'b1;
    end
  end

  always_comb begin
    row_d  = row_q;
    base_d = base_q;
    if (row_inc) begin
      row_d = row_q + RowW'(1);
      if (row_q == {RowW{1'b1}}) begin
        base_d = '0;
      end else begin
        base_d = base_q + AddrW'(COLUMNS);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      base_q <= '0;
    end else if (step_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      base_q <= base_d;
    end
  end

  always_comb begin
    result_o.cell_write      = printable;
    result_o.cell_address    = printable ? (base_q + AddrW'(col_q)) : '0;
    result_o.cell_value      = printable ? {attribute_i, char_code_i} : '0;
    result_o.cursor_position = base_d + AddrW'(col_d);
  end

endmodule

[rtl/text_console_char_writer.sv]
// Text console character writer: top level with input and result registers.
//
// Each accepted character byte moves a text cursor and may write one screen
// cell; every character gives exactly one result carrying the cell write and
// the linear cursor position for the CRTC. The block takes one character per
// clock cycle while the sink accepts results. A character is first held in
// the input register; the cursor update and address computation then write
// the result register, which stalls while a finished result waits. The
// cursor update is a loop through the cursor registers that allows one
// character per cycle. Both registers move together, so a character is
// accepted while a finished result waits only if the input register is empty.
module text_console_char_writer import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = 80
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [AttrW-1:0] cfg_data_i,
  tcw_char_if.sink         char_in,
  tcw_cell_if.source       cell_out
);

  logic             in_valid_q;
  logic [CharW-1:0] in_char_q;
  logic             out_valid_q;
  tcw_result_t      out_q;
  tcw_result_t      result;
  logic [AttrW-1:0] attr_q;
  logic             advance;

  assign advance       = in_valid_q && (!out_valid_q || cell_out.ready);
  assign char_in.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= AttrReset;
    end else if (cfg_we_i) begin
      attr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (char_in.ready) begin
      in_valid_q <= char_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_in.valid && char_in.ready) begin
      in_char_q <= char_in.char_code;
    end
  end

  tcw_cursor #(
    .COLUMNS(COLUMNS)
  ) u_cursor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .char_code_i (in_char_q),
    .attribute_i (attr_q),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (cell_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign cell_out.valid           = out_valid_q;
  assign cell_out.cell_write      = out_q.cell_write;
  assign cell_out.cell_address    = out_q.cell_address;
  assign cell_out.cell_value      = out_q.cell_value;
  assign cell_out.cursor_position = out_q.cursor_position;

  // A character held in the input register stays put until it is processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_char_q))
    else $error("input register lost or changed a pending character");

  // Processing a character always leaves a result for the sink.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed character produced no result");

  // A result without a cell write carries a zero address and value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.cell_write |-> out_q.cell_address == '0 && out_q.cell_value == '0)
    else $error("non-writing result carries cell data");

  // The cursor never points beyond the last row of the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> result.cursor_position < AddrW'(COLUMNS * 256))
    else $error("cursor position beyond the screen");

endmodule
